// ===== rtl/core/okl_pkg.sv =====
// ----------------------------------------------------------------------------
// okl_pkg: shared types and constants of the OKLab converter
// Fixed-point matrix coefficients, cube-root lane type and pipeline sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package okl_pkg;

    // Cube root of a Q0.60 value gives a Q0.20 root, tried from bit 20 down.
    localparam int ROOT_BITS = 21;
    localparam int LMS_BITS  = 62;
    localparam int Q32_BITS  = 33;
    localparam int LMS_CBITS = 28;
    localparam int LAB_CBITS = 31;

    // Stages: two for scaling, one for products, one for sums, one per root bit,
    // one for output products, one for output sums, one for rounding.
    localparam int PIPE_STAGES = 4 + ROOT_BITS + 3;

    // Coefficients are round-half-up of |c| * 2^28, c given to ten decimals.
    localparam longint unsigned ONE_Q28 = 64'd268435456;
    localparam longint unsigned DEC_HALF = 64'd5000000000;
    localparam longint unsigned DEC_ONE  = 64'd10000000000;

    localparam longint unsigned M00 = (64'd4122214708 * ONE_Q28 + DEC_HALF) / DEC_ONE;
    localparam longint unsigned M01 = (64'd5363325363 * ONE_Q28 + DEC_HALF) / DEC_ONE;
    localparam longint unsigned M02 = (64'd514459929 * ONE_Q28 + DEC_HALF) / DEC_ONE;
    localparam longint unsigned M10 = (64'd2119034982 * ONE_Q28 + DEC_HALF) / DEC_ONE;
    localparam longint unsigned M11 = (64'd6806995451 * ONE_Q28 + DEC_HALF) / DEC_ONE;
    localparam longint unsigned M12 = (64'd1073969566 * ONE_Q28 + DEC_HALF) / DEC_ONE;
    localparam longint unsigned M20 = (64'd883024619 * ONE_Q28 + DEC_HALF) / DEC_ONE;
    localparam longint unsigned M21 = (64'd2817188376 * ONE_Q28 + DEC_HALF) / DEC_ONE;
    localparam longint unsigned M22 = (64'd6299787005 * ONE_Q28 + DEC_HALF) / DEC_ONE;

    localparam longint unsigned B00 = (64'd2104542553 * ONE_Q28 + DEC_HALF) / DEC_ONE;
    localparam longint unsigned B01 = (64'd7936177850 * ONE_Q28 + DEC_HALF) / DEC_ONE;
    localparam longint unsigned B02 = (64'd40720468 * ONE_Q28 + DEC_HALF) / DEC_ONE;
    localparam longint unsigned B10 = (64'd19779984951 * ONE_Q28 + DEC_HALF) / DEC_ONE;
    localparam longint unsigned B11 = (64'd24285922050 * ONE_Q28 + DEC_HALF) / DEC_ONE;
    localparam longint unsigned B12 = (64'd4505937099 * ONE_Q28 + DEC_HALF) / DEC_ONE;
    localparam longint unsigned B20 = (64'd259040371 * ONE_Q28 + DEC_HALF) / DEC_ONE;
    localparam longint unsigned B21 = (64'd7827717662 * ONE_Q28 + DEC_HALF) / DEC_ONE;
    localparam longint unsigned B22 = (64'd8086757660 * ONE_Q28 + DEC_HALF) / DEC_ONE;

    localparam logic [LMS_CBITS-1:0] LMS_COEF [3][3] = '{
        '{LMS_CBITS'(M00), LMS_CBITS'(M01), LMS_CBITS'(M02)},
        '{LMS_CBITS'(M10), LMS_CBITS'(M11), LMS_CBITS'(M12)},
        '{LMS_CBITS'(M20), LMS_CBITS'(M21), LMS_CBITS'(M22)}
    };

    localparam logic signed [LAB_CBITS-1:0] LAB_COEF [3][3] = '{
        '{LAB_CBITS'(B00), LAB_CBITS'(B01), -LAB_CBITS'(B02)},
        '{LAB_CBITS'(B10), -LAB_CBITS'(B11), LAB_CBITS'(B12)},
        '{LAB_CBITS'(B20), LAB_CBITS'(B21), -LAB_CBITS'(B22)}
    };

    // Running state of one cube-root lane: radicand, partial root, its square
    // and its cube.
    typedef struct packed {
        logic [LMS_BITS-1:0]    rad;
        logic [ROOT_BITS-1:0]   root;
        logic [2*ROOT_BITS-1:0] sq;
        logic [3*ROOT_BITS-1:0] cube;
    } cbrt_lane_t;

endpackage

`default_nettype wire

// ===== rtl/core/linear_rgb_to_oklab.sv =====
// ----------------------------------------------------------------------------
// linear_rgb_to_oklab: linear RGB plus alpha to OKLab plus alpha
// One pixel per clock unless stalled; cube roots by a chain of one-bit cells.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel takes one pixel item per cycle: linear red, green, blue and
// alpha, each COMPONENT_BITS wide, all-ones meaning 1.0. The m_ channel
// returns one item per pixel: OKLab L (Q0.16), a and b (signed Q1.15, both
// saturated) and alpha unchanged, in the order the pixels came in.
// Throughput is one item per clock while s_tready is high. Between acceptance
// and m_tvalid an item passes in order through the registers for scaling to
// Q0.32, the LMS products, their sums, the cube-root cells (one root bit per
// cell), the output products, their sums, rounding and saturation, and the
// output register.
// Synchronous active-low reset empties the pipeline and the output buffers.
// When the receiver stalls, the output register holds its item and a single
// skid entry catches the next one; only then does the pipeline freeze and
// s_tready drop, so s_tready comes from a register and not from m_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_rgb_to_oklab import okl_pkg::*; #(
    parameter int COMPONENT_BITS = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    // tdata: red_linear, green_linear, blue_linear, alpha_in, zero pad
    input  wire logic [((4*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // tdata: lightness, green_red_axis, blue_yellow_axis, alpha_out, zero pad
    output logic [((48+COMPONENT_BITS+7)/8)*8-1:0] m_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready
);

    localparam int N      = COMPONENT_BITS;
    localparam int OUT_W  = ((48 + N + 7) / 8) * 8;
    localparam int PAD_W  = OUT_W - 48 - N;
    localparam int LMS_PW = Q32_BITS + LMS_CBITS;
    localparam int LAB_PW = ROOT_BITS + 1 + LAB_CBITS;
    localparam int LAB_SW = LAB_PW + 2;

    logic en;
    logic pipe_valid_reg [PIPE_STAGES];
    logic [N-1:0] alpha_reg [PIPE_STAGES];

    logic [Q32_BITS-1:0] frac [3];
    logic [LMS_PW-1:0] lms_prod_reg [3][3];
    logic [LMS_BITS-1:0] lms_sum_reg [3];
    cbrt_lane_t lane [3][ROOT_BITS+1];
    logic signed [LAB_PW-1:0] lab_prod_reg [3][3];
    logic signed [LAB_SW-1:0] lab_sum_reg [3];
    logic signed [LAB_SW-1:0] l_round;
    logic signed [LAB_SW-1:0] a_round;
    logic signed [LAB_SW-1:0] b_round;
    logic [15:0] l_next;
    logic [15:0] a_next;
    logic [15:0] b_next;
    logic [15:0] l_reg;
    logic [15:0] a_reg;
    logic [15:0] b_reg;
    logic [OUT_W-1:0] result_data;

    // The whole pipeline moves together unless the skid entry is occupied.
    assign s_tready = en;

    // Scaling of the three color components.
    for (genvar c = 0; c < 3; c++) begin : g_scale
        okl_to_q32 #(.N(N)) u_to_q32 (
            .aclk (aclk),
            .en   (en),
            .x    (s_tdata[c*N +: N]),
            .u    (frac[c])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    lms_prod_reg[i][j] <= LMS_PW'(frac[j]) * LMS_PW'(LMS_COEF[i][j]);
                end
                lms_sum_reg[i] <= LMS_BITS'(lms_prod_reg[i][0]) + LMS_BITS'(lms_prod_reg[i][1])
                                + LMS_BITS'(lms_prod_reg[i][2]);
            end
        end
    end

    // Cube-root chains, most significant root bit first.
    for (genvar c = 0; c < 3; c++) begin : g_root
        always_comb begin
            lane[c][0]      = '0;
            lane[c][0].rad  = lms_sum_reg[c];
        end
        for (genvar k = 0; k < ROOT_BITS; k++) begin : g_cell
            okl_cbrt_cell #(.BIT(ROOT_BITS - 1 - k)) u_cell (
                .aclk     (aclk),
                .en       (en),
                .lane_in  (lane[c][k]),
                .lane_out (lane[c][k+1])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    lab_prod_reg[i][j] <= LAB_PW'($signed({1'b0, lane[j][ROOT_BITS].root}))
                                        * LAB_PW'(LAB_COEF[i][j]);
                end
                lab_sum_reg[i] <= LAB_SW'(lab_prod_reg[i][0]) + LAB_SW'(lab_prod_reg[i][1])
                                + LAB_SW'(lab_prod_reg[i][2]);
            end
        end
    end

    // Round half up by adding half an output step, then floor with an
    // arithmetic shift, then saturate.
    always_comb begin
        l_round = (lab_sum_reg[0] + (LAB_SW'(1) <<< 31)) >>> 32;
        a_round = (lab_sum_reg[1] + (LAB_SW'(1) <<< 32)) >>> 33;
        b_round = (lab_sum_reg[2] + (LAB_SW'(1) <<< 32)) >>> 33;

        if (l_round < 0) begin
            l_next = 16'd0;
        end else if (l_round > LAB_SW'(65535)) begin
            l_next = 16'hFFFF;
        end else begin
            l_next = l_round[15:0];
        end

        if (a_round < -LAB_SW'(32768)) begin
            a_next = 16'h8000;
        end else if (a_round > LAB_SW'(32767)) begin
            a_next = 16'h7FFF;
        end else begin
            a_next = a_round[15:0];
        end

        if (b_round < -LAB_SW'(32768)) begin
            b_next = 16'h8000;
        end else if (b_round > LAB_SW'(32767)) begin
            b_next = 16'h7FFF;
        end else begin
            b_next = b_round[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l_reg <= l_next;
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    // Valid and alpha travel alongside the arithmetic, one tap per stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < PIPE_STAGES; s++) begin
                pipe_valid_reg[s] <= 1'b0;
            end
        end else if (en) begin
            pipe_valid_reg[0] <= s_tvalid;
            for (int s = 1; s < PIPE_STAGES; s++) begin
                pipe_valid_reg[s] <= pipe_valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            alpha_reg[0] <= s_tdata[3*N +: N];
            for (int s = 1; s < PIPE_STAGES; s++) begin
                alpha_reg[s] <= alpha_reg[s-1];
            end
        end
    end

    if (PAD_W > 0) begin : g_pad
        assign result_data = {PAD_W'(0), alpha_reg[PIPE_STAGES-1], b_reg, a_reg, l_reg};
    end else begin : g_nopad
        assign result_data = {alpha_reg[PIPE_STAGES-1], b_reg, a_reg, l_reg};
    end

    okl_out_skid #(.W(OUT_W)) u_out_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (pipe_valid_reg[PIPE_STAGES-1]),
        .in_data  (result_data),
        .in_ready (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/core/okl_to_q32.sv =====
// ----------------------------------------------------------------------------
// okl_to_q32: component to Q0.32 fraction
// Divides x * 2^32 + floor(D/2) by D = 2^N - 1 in two stages: a digit-sum
// estimate, then a short compare-and-subtract correction.
// ----------------------------------------------------------------------------
`default_nettype none

module okl_to_q32 #(
    parameter int N = 16
) (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire logic [N-1:0] x,
    output logic      [32:0]  u
);

    localparam int W    = N + 32;
    localparam int K    = (W + N - 1) / N;
    localparam int CORR = K + 2;
    localparam int RW   = N + 3;
    localparam int CW   = $clog2(CORR + 1);
    localparam logic [W-1:0]  HALF  = W'((64'd1 << (N - 1)) - 64'd1);
    localparam logic [RW-1:0] DIV_R = RW'((64'd1 << N) - 64'd1);

    logic [W-1:0]  num;
    logic [W-1:0]  qsum;
    logic [W-1:0]  rem_full;
    logic [32:0]   q_reg;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] rem;
    logic [CW-1:0] fix;
    logic [32:0]   u_next;
    logic [32:0]   u_reg;

    // Sum of the shifted copies falls short of the quotient by at most K + 1.
    always_comb begin
        num  = {x, 32'd0} + HALF;
        qsum = '0;
        for (int k = 1; k <= K; k++) begin
            qsum = qsum + (num >> (k * N));
        end
        rem_full = num - ((qsum << N) - qsum);
    end

    always_comb begin
        rem = rem_reg;
        fix = '0;
        for (int i = 0; i < CORR; i++) begin
            if (rem >= DIV_R) begin
                rem = rem - DIV_R;
                fix = fix + CW'(1);
            end
        end
        u_next = q_reg + 33'(fix);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg   <= qsum[32:0];
            rem_reg <= rem_full[RW-1:0];
            u_reg   <= u_next;
        end
    end

    assign u = u_reg;

endmodule

`default_nettype wire

// ===== rtl/core/okl_cbrt_cell.sv =====
// ----------------------------------------------------------------------------
// okl_cbrt_cell: one bit of the floor cube root
// Tries setting root bit BIT using the running square and cube, adds only.
// ----------------------------------------------------------------------------
`default_nettype none

module okl_cbrt_cell import okl_pkg::*; #(
    parameter int BIT = 20
) (
    input  wire logic       aclk,
    input  wire logic       en,
    input  wire cbrt_lane_t lane_in,
    output cbrt_lane_t      lane_out
);

    cbrt_lane_t lane_reg;
    cbrt_lane_t lane_next;
    logic [63:0] trial_cube;
    logic [63:0] r2_64;
    logic [63:0] r_64;

    // (r + 2^b)^3 = r^3 + 3 r^2 2^b + 3 r 2^2b + 2^3b
    always_comb begin
        r2_64      = 64'(lane_in.sq);
        r_64       = 64'(lane_in.root);
        trial_cube = 64'(lane_in.cube) + (((r2_64 << 1) + r2_64) << BIT)
                   + (((r_64 << 1) + r_64) << (2 * BIT)) + (64'd1 << (3 * BIT));
        lane_next = lane_in;
        if (trial_cube <= 64'(lane_in.rad)) begin
            lane_next.root = lane_in.root | (ROOT_BITS'(1) << BIT);
            lane_next.sq   = lane_in.sq + ((2 * ROOT_BITS)'(lane_in.root) << (BIT + 1))
                           + ((2 * ROOT_BITS)'(1) << (2 * BIT));
            lane_next.cube = trial_cube[3*ROOT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

`default_nettype wire

// ===== rtl/core/okl_out_skid.sv =====
// ----------------------------------------------------------------------------
// okl_out_skid: output register with one skid entry
// Keeps the pipeline moving in a receiver stall until the skid entry fills.
// ----------------------------------------------------------------------------
`default_nettype none

module okl_out_skid #(
    parameter int W = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    input  wire logic [W-1:0] in_data,
    output logic              in_ready,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [W-1:0] m_tdata
);

    logic         out_valid_reg;
    logic [W-1:0] out_data_reg;
    logic         skid_valid_reg;
    logic [W-1:0] skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !m_tready) begin
            if (in_valid && !skid_valid_reg) begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= in_data;
            end
        end else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            out_data_reg   <= skid_data_reg;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= in_valid;
            out_data_reg  <= in_data;
        end
    end

    assign in_ready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_stall_catches: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready && in_valid && !skid_valid_reg) |=> skid_valid_reg)
        else $error("item arriving during stall was not caught");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!out_valid_reg && !skid_valid_reg))
        else $error("buffers not empty after reset");

endmodule

`default_nettype wire
